// ----- hw/rtl/m61alu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61alu_pkg
// Shared types and constants for the modular ALU over the field mod 2^61-1.
// ----------------------------------------------------------------------------
package m61alu_pkg;

    localparam int FIELD_W   = 61;
    localparam int EXP_W     = 64;
    localparam int OP_W      = 2;
    localparam int HALF_W    = 32;
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 64;

    // Mersenne prime 2^61 - 1: all ones at field width
    localparam logic [FIELD_W-1:0] M61_PRIME = {FIELD_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_POW = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WAIT_PROD,
        ST_EXP_BIT,
        ST_WAIT_ACC,
        ST_EXP_SHIFT,
        ST_WAIT_SQ,
        ST_OUT
    } state_t;

endpackage

// ----- hw/rtl/m61alu_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61alu_mul
// Iterative modular multiplier mod 2^61-1: four 32x32 partial products, one
// per cycle, accumulated into a 122-bit product, then two Mersenne folds.
// ----------------------------------------------------------------------------
module m61alu_mul
    import m61alu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [FIELD_W-1:0] x,
    input  logic [FIELD_W-1:0] y,
    output logic               done,
    output logic [FIELD_W-1:0] product
);

    localparam logic [2:0] STEP_LAST_PP   = 3'd3;
    localparam logic [2:0] STEP_FIRST_ADD = 3'd1;
    localparam logic [2:0] STEP_LAST_ADD  = 3'd4;
    localparam logic [2:0] STEP_FOLD      = 3'd5;
    localparam logic [2:0] STEP_LAST      = 3'd6;

    logic                    busy_reg;
    logic [2:0]              step_reg;
    logic                    done_reg;
    logic [FIELD_W-1:0]      x_reg, y_reg;
    logic [2*HALF_W-1:0]     pp_reg, pp_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [FIELD_W:0]        fold_reg, fold_next;
    logic [FIELD_W-1:0]      product_reg, product_next;
    logic [HALF_W-1:0]       x_half, y_half;
    logic [PROD_W-1:0]       pp_wide;
    logic [FIELD_W-1:0]      fold2;

    // partial product select: steps 0..3 give ll, lh, hl, hh
    always_comb begin
        x_half  = step_reg[1] ? {{(2*HALF_W-FIELD_W){1'b0}}, x_reg[FIELD_W-1:HALF_W]}
                              : x_reg[HALF_W-1:0];
        y_half  = step_reg[0] ? {{(2*HALF_W-FIELD_W){1'b0}}, y_reg[FIELD_W-1:HALF_W]}
                              : y_reg[HALF_W-1:0];
        pp_next = x_half * y_half;
    end

    // align the previous partial product and accumulate
    always_comb begin
        case (step_reg)
            3'd1:    pp_wide = {{(PROD_W-2*HALF_W){1'b0}}, pp_reg};
            3'd2,
            3'd3:    pp_wide = {{(PROD_W-2*HALF_W){1'b0}}, pp_reg} << HALF_W;
            3'd4:    pp_wide = {{(PROD_W-2*HALF_W){1'b0}}, pp_reg} << (2 * HALF_W);
            default: pp_wide = '0;
        endcase
        acc_next = acc_reg + pp_wide;
    end

    // Mersenne folding: low 61 bits plus high part, twice, then map P to 0
    always_comb begin
        fold_next    = {1'b0, acc_reg[FIELD_W-1:0]} + {1'b0, acc_reg[PROD_W-1:FIELD_W]};
        fold2        = fold_reg[FIELD_W-1:0] + {{(FIELD_W-1){1'b0}}, fold_reg[FIELD_W]};
        product_next = (fold2 == M61_PRIME) ? '0 : fold2;
    end

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg <= STEP_LAST_PP)
                pp_reg <= pp_next;
            if (step_reg >= STEP_FIRST_ADD && step_reg <= STEP_LAST_ADD)
                acc_reg <= acc_next;
            if (step_reg == STEP_FOLD)
                fold_reg <= fold_next;
            if (step_reg == STEP_LAST)
                product_reg <= product_next;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

// ----- hw/rtl/mersenne61_modular_alu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mersenne61_modular_alu_core
// Add, subtract, multiply and exponentiate modulo the prime 2^61-1.
// ----------------------------------------------------------------------------
// Usage:
//   One request goes in on the s_ stream; exactly one result comes out on
//   the m_ stream. A request carries opcode in s_tuser and operands a, b in
//   s_tdata; the result carries the field value in m_tdata and the operand
//   error flag in m_tuser.
//   The block works on one request at a time: s_tready is high only while
//   idle, and drops from the accepting transfer until the result is taken.
//   Add, subtract and any operand error are resolved in the dispatch state;
//   multiply runs once through the shared multiplier. Exponentiation runs a
//   modular multiply per set exponent bit and a square per exponent bit
//   below the top set bit: an all-ones exponent takes 127 multiplies.
//   The one shared multiplier forms four 32x32 partial products in turn,
//   accumulates them, then applies two Mersenne folds.
//   A result holds on the m_ side while m_tready is low; the next request
//   is taken only after that result transfer.
//   Reset (aresetn low, synchronous) returns to idle and drops any request
//   in flight; there is no other state to clear.
// ----------------------------------------------------------------------------
module mersenne61_modular_alu_core
    import m61alu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [60:0] operand_a, [124:61] operand_b
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [60:0] result
    output logic [0:0]           m_tuser    // [0] operand_error
);

    state_t                  state_reg, state_next;
    opcode_t                 op_reg;
    logic [FIELD_W-1:0]      base_reg;
    logic [EXP_W-1:0]        exp_reg;
    logic [FIELD_W-1:0]      acc_reg;
    logic [FIELD_W-1:0]      result_reg;
    logic                    error_reg;

    logic                    bad;
    logic [FIELD_W:0]        add_sum;
    logic [FIELD_W-1:0]      add_res;
    logic [FIELD_W:0]        sub_diff;
    logic [FIELD_W-1:0]      sub_res;
    logic [EXP_W-1:0]        exp_shifted;
    logic                    mul_start;
    logic                    mul_done;
    logic [FIELD_W-1:0]      mul_x, mul_y, mul_product;

    // operand check and combinational add / subtract
    always_comb begin
        bad = (base_reg == M61_PRIME) ||
              ((op_reg != OP_POW) &&
               ((|exp_reg[EXP_W-1:FIELD_W]) || (exp_reg[FIELD_W-1:0] == M61_PRIME)));
        add_sum  = {1'b0, base_reg} + {1'b0, exp_reg[FIELD_W-1:0]};
        // s >= P: s - P == (s + 1) mod 2^61
        add_res  = (add_sum[FIELD_W] || (add_sum[FIELD_W-1:0] == M61_PRIME))
                   ? add_sum[FIELD_W-1:0] + 1'b1 : add_sum[FIELD_W-1:0];
        sub_diff = {1'b0, base_reg} - {1'b0, exp_reg[FIELD_W-1:0]};
        // borrow: adding P == subtracting 1 mod 2^61
        sub_res  = sub_diff[FIELD_W] ? sub_diff[FIELD_W-1:0] - 1'b1
                                     : sub_diff[FIELD_W-1:0];
        exp_shifted = exp_reg >> 1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid)
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (bad)
                    state_next = ST_OUT;
                else begin
                    case (op_reg)
                        OP_MUL:  state_next = ST_WAIT_PROD;
                        OP_POW:  state_next = ST_EXP_BIT;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_WAIT_PROD: begin
                if (mul_done)
                    state_next = ST_OUT;
            end
            ST_EXP_BIT: begin
                if (exp_reg == '0)
                    state_next = ST_OUT;
                else if (exp_reg[0])
                    state_next = ST_WAIT_ACC;
                else
                    state_next = ST_EXP_SHIFT;
            end
            ST_WAIT_ACC: begin
                if (mul_done)
                    state_next = ST_EXP_SHIFT;
            end
            ST_EXP_SHIFT: begin
                if (exp_shifted != '0)
                    state_next = ST_WAIT_SQ;
                else
                    state_next = ST_EXP_BIT;
            end
            ST_WAIT_SQ: begin
                if (mul_done)
                    state_next = ST_EXP_BIT;
            end
            ST_OUT: begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and multiplier control
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        mul_start = 1'b0;
        case (state_reg)
            ST_DISPATCH:  mul_start = !bad && (op_reg == OP_MUL);
            ST_EXP_BIT:   mul_start = (exp_reg != '0) && exp_reg[0];
            ST_EXP_SHIFT: mul_start = (exp_shifted != '0);
            default:      mul_start = 1'b0;
        endcase
        // acc*base on a set bit, base*base to square, a*b for plain multiply
        mul_x = (state_reg == ST_EXP_BIT) ? acc_reg : base_reg;
        mul_y = (state_reg == ST_DISPATCH) ? exp_reg[FIELD_W-1:0] : base_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // operand, accumulator and result registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_reg   <= opcode_t'(s_tuser);
                    base_reg <= s_tdata[FIELD_W-1:0];
                    exp_reg  <= s_tdata[FIELD_W+EXP_W-1:FIELD_W];
                end
            end
            ST_DISPATCH: begin
                error_reg <= bad;
                acc_reg   <= {{(FIELD_W-1){1'b0}}, 1'b1};
                if (bad)
                    result_reg <= '0;
                else if (op_reg == OP_ADD)
                    result_reg <= add_res;
                else if (op_reg == OP_SUB)
                    result_reg <= sub_res;
            end
            ST_WAIT_PROD: begin
                if (mul_done)
                    result_reg <= mul_product;
            end
            ST_EXP_BIT: begin
                if (exp_reg == '0)
                    result_reg <= acc_reg;
            end
            ST_WAIT_ACC: begin
                if (mul_done)
                    acc_reg <= mul_product;
            end
            ST_EXP_SHIFT: begin
                exp_reg <= exp_shifted;
            end
            ST_WAIT_SQ: begin
                if (mul_done)
                    base_reg <= mul_product;
            end
            default: ;
        endcase
    end

    m61alu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .x       (mul_x),
        .y       (mul_y),
        .done    (mul_done),
        .product (mul_product)
    );

    assign m_tdata = {{(M_TDATA_W-FIELD_W){1'b0}}, result_reg};
    assign m_tuser = error_reg;

endmodule

// ----- hw/rtl/m61alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m61alu_checker
// Port-level checks for the mod 2^61-1 ALU, bound to the top level.
// ----------------------------------------------------------------------------
module m61alu_checker
    import m61alu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time: no intake while a result is offered
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // an accepted request never yields a result in the very next cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid && !s_tready)
        else $error("block not busy after accept");

    // results are reduced, and an error result is zero
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[FIELD_W-1:0] != M61_PRIME) &&
                     (m_tdata[M_TDATA_W-1:FIELD_W] == '0) &&
                     (!m_tuser[0] || (m_tdata[FIELD_W-1:0] == '0)))
        else $error("result not reduced or error result nonzero");

endmodule

bind mersenne61_modular_alu_core m61alu_checker u_m61alu_checker (.*);
